// ===== rtl/core/hkt_pkg.sv =====
`timescale 1ns / 1ps

package hkt_pkg;

  // Request codes carried in the action field.
  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_REPLACE = 3'd1;
  localparam logic [2:0] ACT_FIND    = 3'd2;
  localparam logic [2:0] ACT_DELETE  = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  // FNV-1 64-bit: the prime is 2^40 + 0x1B3, so a multiply is a shift plus a narrow product.
  localparam logic [63:0] FNV_BASIS       = 64'hCBF29CE484222325;
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] key;
    logic [15:0] handle;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] old_handle;
    logic        status;
    logic [8:0]  entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic hash_step;
    logic mod_step;
    logic clr_step;
    logic rd_head;
    logic walk_init;
    logic rd_slot;
    logic walk_adv;
    logic take_hit;
    logic set_full;
    logic scan_rd;
    logic scan_adv;
    logic wr_new;
    logic wr_repl;
    logic wr_del;
    logic load_rsp;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] act;
    logic       hash_last;
    logic       mod_last;
    logic       clr_last;
    logic       walk_end;
    logic       hit;
    logic       used;
    logic       found;
    logic       full;
  } sts_t;

endpackage

// ===== rtl/core/hkt_dp.sv =====
`timescale 1ns / 1ps

module hkt_dp
  import hkt_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int BUCKETS     = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  localparam int SW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int BW   = $clog2(BUCKETS);
  localparam int MAXN = (CAPACITY > BUCKETS) ? CAPACITY : BUCKETS;
  localparam int CW   = $clog2(MAXN);
  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [SW-1:0] NIL = SW'(CAPACITY);

  logic [2:0]             act;
  logic [63:0]            key;
  logic [63:0]            kshift;
  logic [HANDLE_BITS-1:0] hnd;
  logic [63:0]            h;
  logic [2:0]             bcnt;
  logic [5:0]             mcnt;
  logic [BW:0]            rem;
  logic [SW-1:0]          cur;
  logic [SW-1:0]          prev;
  logic [SW-1:0]          steps;
  logic [SW-1:0]          s;
  logic [SW-1:0]          nxt_s;
  logic                   found;
  logic [HANDLE_BITS-1:0] old;
  logic                   full;
  logic [SW-1:0]          scan;
  logic [SW-1:0]          low_free;
  logic [SW-1:0]          count;
  logic [CW-1:0]          clr_idx;

  logic [SW-1:0]          head_mem [BUCKETS];
  logic [63:0]            key_mem  [CAPACITY];
  logic [HANDLE_BITS-1:0] hnd_mem  [CAPACITY];
  logic [SW-1:0]          nxt_mem  [CAPACITY];
  logic                   used_mem [CAPACITY];

  logic [SW-1:0]          head_rd;
  logic [63:0]            key_rd;
  logic [HANDLE_BITS-1:0] hnd_rd;
  logic [SW-1:0]          nxt_rd;
  logic                   used_rd;

  logic [63:0]   h_next;
  logic [BW:0]   rem_shift;
  logic [BW:0]   rem_next;
  logic [BW-1:0] bkt;
  logic          clr_in_head;
  logic          clr_in_slot;
  logic [AW-1:0] scan_ra;
  logic [AW-1:0] used_ra;
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [SW-1:0] head_wd;
  logic          used_we;
  logic [AW-1:0] used_wa;

  // One FNV-1 round per cycle, one key byte at a time.
  assign h_next = ((h << FNV_PRIME_SHIFT) + 64'(h * FNV_PRIME_LO)) ^ {56'd0, kshift[7:0]};

  // Restoring remainder, one hash bit per cycle from the top, for a bucket count
  // that is not a power of two.
  assign rem_shift = {rem[BW-1:0], h[~mcnt]};
  assign rem_next  = (rem_shift >= (BW+1)'(BUCKETS)) ? rem_shift - (BW+1)'(BUCKETS) : rem_shift;
  assign bkt       = POW2 ? h[BW-1:0] : rem[BW-1:0];

  assign clr_in_head = ({1'b0, clr_idx} < (CW+1)'(BUCKETS));
  assign clr_in_slot = ({1'b0, clr_idx} < (CW+1)'(CAPACITY));
  assign scan_ra     = cmd.scan_rd ? low_free[AW-1:0] : AW'(scan + 1'b1);
  assign used_ra     = cmd.rd_slot ? cur[AW-1:0] : scan_ra;

  assign head_we = (cmd.clr_step && clr_in_head) || cmd.wr_new || (cmd.wr_del && prev == NIL);
  assign head_wa = cmd.clr_step ? clr_idx[BW-1:0] : bkt;
  assign head_wd = cmd.clr_step ? NIL : (cmd.wr_new ? scan : nxt_s);

  assign used_we = (cmd.clr_step && clr_in_slot) || cmd.wr_new || cmd.wr_del;
  assign used_wa = cmd.clr_step ? clr_idx[AW-1:0] : (cmd.wr_new ? scan[AW-1:0] : s[AW-1:0]);

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (cmd.rd_head) begin
      head_rd <= head_mem[bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      key_mem[scan[AW-1:0]] <= key;
      hnd_mem[scan[AW-1:0]] <= hnd;
      nxt_mem[scan[AW-1:0]] <= head_rd;
    end
    if (cmd.wr_repl) begin
      hnd_mem[s[AW-1:0]] <= hnd;
    end
    if (cmd.wr_del && prev != NIL) begin
      nxt_mem[prev[AW-1:0]] <= nxt_s;
    end
    if (used_we) begin
      used_mem[used_wa] <= cmd.wr_new;
    end
    if (cmd.rd_slot) begin
      key_rd <= key_mem[cur[AW-1:0]];
      hnd_rd <= hnd_mem[cur[AW-1:0]];
      nxt_rd <= nxt_mem[cur[AW-1:0]];
    end
    if (cmd.rd_slot || cmd.scan_rd || cmd.scan_adv) begin
      used_rd <= used_mem[used_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= req.action;
      key    <= req.key;
      kshift <= req.key;
      hnd    <= HANDLE_BITS'(req.handle);
      h      <= FNV_BASIS;
      bcnt   <= '0;
      mcnt   <= '0;
      rem    <= '0;
      found  <= 1'b0;
      old    <= '0;
      full   <= 1'b0;
    end
    if (cmd.hash_step) begin
      h      <= h_next;
      kshift <= kshift >> 8;
      bcnt   <= bcnt + 1'b1;
    end
    if (cmd.mod_step) begin
      rem  <= rem_next;
      mcnt <= mcnt + 1'b1;
    end
    if (cmd.walk_init) begin
      cur   <= head_rd;
      prev  <= NIL;
      steps <= '0;
    end
    if (cmd.walk_adv) begin
      prev  <= cur;
      cur   <= nxt_rd;
      steps <= steps + 1'b1;
    end
    if (cmd.take_hit) begin
      s     <= cur;
      nxt_s <= nxt_rd;
      found <= 1'b1;
      old   <= hnd_rd;
    end
    if (cmd.set_full) begin
      full <= 1'b1;
    end
    if (cmd.scan_rd) begin
      scan <= low_free;
    end
    if (cmd.scan_adv) begin
      scan <= scan + 1'b1;
    end
    if (cmd.load_rsp) begin
      rsp <= '{found: found, old_handle: 16'(old), status: full, entry_count: 9'(count)};
    end
  end

  // Occupancy, lowest-free bound and sweep index.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      low_free <= '0;
      clr_idx  <= '0;
    end else if (cmd.clr_step) begin
      count    <= '0;
      low_free <= '0;
      clr_idx  <= (clr_idx == CW'(MAXN - 1)) ? '0 : clr_idx + 1'b1;
    end else if (cmd.wr_new) begin
      count    <= count + 1'b1;
      low_free <= scan + 1'b1;
    end else if (cmd.wr_del) begin
      if (count != '0) begin
        count <= count - 1'b1;
      end
      if (s < low_free) begin
        low_free <= s;
      end
    end
  end

  assign sts.act       = act;
  assign sts.hash_last = (bcnt == 3'd7);
  assign sts.mod_last  = POW2 || (mcnt == 6'd63);
  assign sts.clr_last  = (clr_idx == CW'(MAXN - 1));
  assign sts.walk_end  = (cur >= NIL) || (steps == NIL);
  assign sts.hit       = used_rd && (key_rd == key);
  assign sts.used      = used_rd;
  assign sts.found     = found;
  assign sts.full      = (count == NIL);

endmodule

// ===== rtl/core/hkt_ctrl.sv =====
`timescale 1ns / 1ps

module hkt_ctrl
  import hkt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_HASH  = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_HEAD  = 4'd5;
  localparam logic [3:0] S_WINIT = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_ACT   = 4'd9;
  localparam logic [3:0] S_SCAN  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       reply;
  logic       reply_next;
  logic       is_new;

  assign req_stall = (state != S_IDLE);
  assign is_new    = (sts.act == ACT_INSERT) || (sts.act == ACT_REPLACE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    reply_next = reply;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.act == ACT_CLEAR) begin
          reply_next = 1'b1;
          state_next = S_CLR;
        end else if (sts.act inside {ACT_INSERT, ACT_REPLACE, ACT_FIND, ACT_DELETE}) begin
          state_next = S_HASH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = reply ? S_DONE : S_IDLE;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_WINIT;
      end
      S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_next    = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_end) begin
          state_next = S_ACT;
        end else begin
          cmd.rd_slot = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_ACT;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next   = S_WALK;
        end
      end
      S_ACT: begin
        state_next = S_DONE;
        if (sts.found) begin
          cmd.wr_repl = (sts.act == ACT_REPLACE);
          cmd.wr_del  = (sts.act == ACT_DELETE);
        end else if (is_new) begin
          if (sts.full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.scan_rd = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.used) begin
          cmd.scan_adv = 1'b1;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      reply     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      reply <= (state_next == S_IDLE) ? 1'b0 : reply_next;
      if (cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/hashed_key_table.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload  Handshake
// req       in         req_t    req_valid / req_stall  (action, key, handle)
// rsp       out        rsp_t    rsp_valid / rsp_stall  (found, old_handle, status, entry_count)
//
// One request at a time. A request is decoded, hashed one key byte at a time,
// reduced to a bucket (one hash bit at a time when BUCKETS is not a power of
// two), and the bucket head is fetched; the chain is then walked link by link,
// each link read and compared, until a match or the chain's end. An action step
// follows, then a slot-by-slot probe for a free slot when a new key is stored,
// and last the response register is loaded. A clear request, and reset itself,
// sweeps the memories, marking every bucket head empty and every slot unused.
// A finished response waits in its register while the next request is taken.
module hashed_key_table
  import hkt_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int BUCKETS     = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences hashing, the chain walk, the free-slot scan and
  // the clearing sweep; the datapath holds every memory and register they act on.
  hkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hkt_dp #(
    .CAPACITY    (CAPACITY),
    .BUCKETS     (BUCKETS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ===== verif/tb_hashed_key_table.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the chained hash table. An initial block queues
// requests; a clocked driver presents them with random idle bursts, and each
// request is run through a behavioural copy of the table at the moment it is
// accepted. The resulting expected response is queued, and a clocked monitor
// compares every response, field by field, against the oldest one waiting.
module tb_hashed_key_table;
  import hkt_pkg::*;

  localparam int SLOTS  = 256;
  localparam int NBUCK  = 64;
  localparam logic [8:0]  NO_SLOT = 9'd256;
  localparam logic [63:0] FNV_MUL = 64'h0000_0100_0000_01B3;
  localparam logic [2:0]  ACT_SPARE_LO  = 3'd5;
  localparam logic [2:0]  ACT_SPARE_MID = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;

  typedef struct {
    req_t r;
    bit   drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  hashed_key_table dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // The shadow table: chain heads per bucket and the slot pool.
  logic [8:0]  chain_head [NBUCK];
  logic [63:0] slot_key   [SLOTS];
  logic [15:0] slot_hdl   [SLOTS];
  logic [8:0]  slot_link  [SLOTS];
  bit          slot_busy  [SLOTS];
  int          held;

  pending_t request_q[$];
  rsp_t     response_q[$];
  int       errors = 0;
  int       send_gap = 0;
  int       stall_left = 0;

  function automatic logic [5:0] bucket_of_key(logic [63:0] k);
    logic [63:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < 8; i++) h = (h * FNV_MUL) ^ {56'd0, k[8*i +: 8]};
    return 6'(h % NBUCK);
  endfunction

  // Applies one request to the shadow table and returns the response due.
  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    logic [5:0] b;
    logic [8:0] cur, prv, hit, hit_prv;
    int steps, f;
    o = '0;
    if (r.action == ACT_CLEAR) begin
      foreach (chain_head[i]) chain_head[i] = NO_SLOT;
      foreach (slot_busy[i]) slot_busy[i] = 0;
      held = 0;
    end else if (r.action <= ACT_DELETE) begin
      b = bucket_of_key(r.key);
      cur = chain_head[b];
      prv = NO_SLOT;
      hit = NO_SLOT;
      hit_prv = NO_SLOT;
      steps = 0;
      while (cur < NO_SLOT && steps < SLOTS && hit == NO_SLOT) begin
        if (slot_busy[cur[7:0]] && slot_key[cur[7:0]] == r.key) begin
          hit = cur;
          hit_prv = prv;
        end else begin
          prv = cur;
          cur = slot_link[cur[7:0]];
          steps++;
        end
      end
      if (hit != NO_SLOT) begin
        o.found = 1'b1;
        o.old_handle = slot_hdl[hit[7:0]];
      end
      if (r.action == ACT_INSERT || r.action == ACT_REPLACE) begin
        if (hit != NO_SLOT) begin
          if (r.action == ACT_REPLACE) slot_hdl[hit[7:0]] = r.handle;
        end else begin
          f = -1;
          for (int i = 0; i < SLOTS && f < 0; i++) if (!slot_busy[i]) f = i;
          if (f < 0) begin
            o.status = 1'b1;
          end else begin
            slot_key[f[7:0]] = r.key;
            slot_hdl[f[7:0]] = r.handle;
            slot_link[f[7:0]] = chain_head[b];
            slot_busy[f[7:0]] = 1;
            chain_head[b] = f[8:0];
            held++;
          end
        end
      end else if (r.action == ACT_DELETE && hit != NO_SLOT) begin
        if (hit_prv != NO_SLOT) slot_link[hit_prv[7:0]] = slot_link[hit[7:0]];
        else chain_head[b] = slot_link[hit[7:0]];
        slot_busy[hit[7:0]] = 0;
        if (held > 0) held--;
      end
    end
    o.entry_count = held[8:0];
    return o;
  endfunction

  task automatic queue_request(logic [2:0] a, logic [63:0] k, logic [15:0] h,
                               bit drain = 0);
    pending_t p;
    p.r.action = a;
    p.r.key = k;
    p.r.handle = h;
    p.drain = drain;
    request_q.push_back(p);
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("response %s differs: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  // Driver. The next valid value is worked out in a variable so that valid
  // gets exactly one nonblocking assignment per clock edge.
  always @(posedge clk) begin
    logic nv;
    req_t nr;
    bit quiet;
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      nv = req_valid;
      nr = req;
      quiet = request_q.size() < 150;
      if (req_valid && !req_stall) begin
        response_q.push_back(table_apply(req));
        nv = 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0) begin
          // A draining request waits until every response due has come back.
          if (request_q[0].drain && response_q.size() > 0) begin
          end else begin
            nr = request_q.pop_front().r;
            nv = 1'b1;
          end
        end
      end
      req_valid <= nv;
      req <= nr;
    end
  end

  // Monitor and receiver back-pressure.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (response_q.size() == 0) begin
          $display("response arrived with none outstanding");
          errors++;
        end else begin
          want = response_q.pop_front();
          if (rsp.found !== want.found)
            report("found", 64'(rsp.found), 64'(want.found));
          if (rsp.old_handle !== want.old_handle)
            report("old_handle", 64'(rsp.old_handle), 64'(want.old_handle));
          if (rsp.status !== want.status)
            report("status", 64'(rsp.status), 64'(want.status));
          if (rsp.entry_count !== want.entry_count)
            report("entry_count", 64'(rsp.entry_count), 64'(want.entry_count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (request_q.size() >= 150 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [63:0] pool [320];
    int psize, mode, n;
    logic [2:0] a;
    foreach (chain_head[i]) chain_head[i] = NO_SLOT;
    foreach (slot_busy[i]) slot_busy[i] = 0;
    held = 0;

    // Directed: empty lookups, extreme keys and handles, each action,
    // existing keys, spare action codes and a clear.
    queue_request(ACT_FIND, 64'd0, 16'd0);
    queue_request(ACT_DELETE, '1, 16'hFFFF);
    queue_request(ACT_INSERT, 64'd0, 16'd0);
    queue_request(ACT_INSERT, '1, 16'hFFFF);
    queue_request(ACT_INSERT, '1, 16'h1234);
    queue_request(ACT_REPLACE, 64'd0, 16'hFFFF);
    queue_request(ACT_REPLACE, 64'h8000_0000_0000_0001, 16'hA5A5);
    queue_request(ACT_FIND, 64'd0, 16'd0);
    queue_request(ACT_FIND, '1, 16'd0);
    queue_request(ACT_SPARE_LO, '1, 16'hFFFF);
    queue_request(ACT_SPARE_MID, 64'd0, 16'd0);
    queue_request(ACT_SPARE_HI, '1, 16'hFFFF);
    queue_request(ACT_DELETE, '1, 16'd0);
    queue_request(ACT_DELETE, '1, 16'd0);
    queue_request(ACT_FIND, 64'h8000_0000_0000_0001, 16'd0);
    queue_request(ACT_CLEAR, '1, 16'hFFFF);
    queue_request(ACT_FIND, 64'd0, 16'd0);

    // Random blocks. Fill blocks push the table past full so refusals,
    // long chains and deletes from mid-chain all occur.
    for (int blk = 0; blk < 11; blk++) begin
      mode = (blk % 3 == 1) ? 1 : 0;
      psize = mode ? 320 : $urandom_range(4, 40);
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      n = mode ? 330 : 90;
      for (int i = 0; i < n; i++) begin
        if (mode) a = ($urandom_range(0, 9) < 8) ? ACT_INSERT : ACT_REPLACE;
        else a = 3'($urandom_range(ACT_INSERT, ACT_DELETE));
        if ($urandom_range(0, 60) == 0) a = 3'($urandom_range(ACT_CLEAR, ACT_SPARE_HI));
        queue_request(a, ($urandom_range(0, 30) == 0) ? {$urandom, $urandom}
                      : pool[$urandom_range(0, psize - 1)], 16'($urandom_range(0, 16'hFFFF)),
                      (i == 0 && blk == 5));
      end
      if (mode) begin
        for (int i = 0; i < 40; i++)
          queue_request(3'($urandom_range(ACT_FIND, ACT_DELETE)),
                        pool[$urandom_range(0, 319)], 16'($urandom_range(0, 16'hFFFF)));
        queue_request(ACT_CLEAR, {$urandom, $urandom}, 16'($urandom_range(0, 16'hFFFF)));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (request_q.size() == 0 && !req_valid && response_q.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0 && response_q.size() == 0) begin
      $display("hashed_key_table: match");
    end else begin
      $display("hashed_key_table: mismatch");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("hashed_key_table: mismatch");
    $finish;
  end

endmodule

// ===== hashed_key_table.f =====
rtl/core/hkt_pkg.sv
rtl/core/hkt_dp.sv
rtl/core/hkt_ctrl.sv
rtl/core/hashed_key_table.sv
verif/tb_hashed_key_table.sv
